>>> rtl/input_event_rule_mapper_unit_assert.svh
// ----------------------------------------------------------------------------
// Input event rule mapper assertion macros
// Shorthand for clocked, reset-qualified port checks.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_RULE_MAPPER_UNIT_ASSERT_SVH
`define INPUT_EVENT_RULE_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define IERM_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IERM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iermap_pkg.sv
// ----------------------------------------------------------------------------
// iermap_pkg
// Shared types, codes and widths of the input event rule mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package iermap_pkg;

    localparam int RULE_SLOTS_DEF = 16;
    localparam int Q_DEPTH        = 2;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    // request modes
    localparam logic [1:0] MODE_EVENT  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // result kinds
    localparam logic [1:0] RK_SERIAL = 2'd0;
    localparam logic [1:0] RK_CAN    = 2'd1;
    localparam logic [1:0] RK_ADD    = 2'd2;
    localparam logic [1:0] RK_REMOVE = 2'd3;

    typedef struct packed {
        logic [5:0]         pad;
        logic [7:0]         slot;
        logic [28:0]        can_id;
        logic [3:0]         frame_length;
        logic [2:0]         placement;
        logic [1:0]         out_kind;
        logic signed [15:0] max_value;
        logic signed [15:0] min_value;
        logic signed [15:0] value;
        logic [15:0]        input_id;
        logic [3:0]         event_type;
        logic [7:0]         device_index;
    } in_payload_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         slot;
        logic [28:0]        can_id;
        logic [3:0]         frame_length;
        logic [2:0]         placement;
        logic [1:0]         out_kind;
        logic signed [15:0] max_value;
        logic signed [15:0] min_value;
        logic signed [15:0] value;
        logic [15:0]        input_id;
        logic [3:0]         event_type;
        logic [7:0]         device_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [28:0] frame_id;
        logic [3:0]  frame_bytes;
        logic [63:0] frame_data;
        logic [5:0]  reply_slot;
        logic        ok;
        logic [6:0]  rules_in_use;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        pad;
        logic [6:0]  rules_in_use;
        logic        ok;
        logic [5:0]  reply_slot;
        logic [63:0] frame_data;
        logic [3:0]  frame_bytes;
        logic [28:0] frame_id;
    } out_payload_t;

endpackage

`default_nettype wire

>>> rtl/iermap_ram.sv
// ----------------------------------------------------------------------------
// iermap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iermap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/iermap_front.sv
// ----------------------------------------------------------------------------
// iermap_front
// Unpacks incoming requests, drops unknown modes, feeds the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module iermap_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [iermap_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [iermap_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                               q_valid,
    input  logic                               q_ready,
    output iermap_pkg::cmd_t                   q_cmd
);

    import iermap_pkg::*;

    in_payload_t pl;
    logic        known;

    assign pl = s_tdata;

    always_comb begin
        unique case (s_tuser) inside
            MODE_EVENT, MODE_ADD, MODE_REMOVE: known = 1'b1;
            default:                           known = 1'b0;
        endcase
    end

    // unknown modes are taken and discarded
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid && known;

    always_comb begin
        q_cmd.mode         = s_tuser;
        q_cmd.slot         = pl.slot;
        q_cmd.can_id       = pl.can_id;
        q_cmd.frame_length = pl.frame_length;
        q_cmd.placement    = pl.placement;
        q_cmd.out_kind     = pl.out_kind;
        q_cmd.max_value    = pl.max_value;
        q_cmd.min_value    = pl.min_value;
        q_cmd.value        = pl.value;
        q_cmd.input_id     = pl.input_id;
        q_cmd.event_type   = pl.event_type;
        q_cmd.device_index = pl.device_index;
    end

endmodule

`default_nettype wire

>>> rtl/iermap_queue.sv
// ----------------------------------------------------------------------------
// iermap_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module iermap_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  iermap_pkg::cmd_t push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output iermap_pkg::cmd_t pop_cmd
);

    import iermap_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/iermap_back.sv
// ----------------------------------------------------------------------------
// iermap_back
// Rule table, add/remove handling and one-slot-per-cycle event scan, held while a frame waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module iermap_back #(
    parameter int RULE_SLOTS = iermap_pkg::RULE_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  iermap_pkg::cmd_t cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output iermap_pkg::res_t m_res
);

    import iermap_pkg::*;

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [1:0] OUT_SERIAL = 2'd0;
    localparam logic [1:0] OUT_CAN    = 2'd1;

    localparam logic [2:0] FMT_ASCII = 3'd1;
    localparam logic [2:0] FMT_LE16  = 3'd2;
    localparam logic [2:0] FMT_BE16  = 3'd3;

    typedef struct packed {
        logic [7:0]         dev;
        logic [3:0]         etype;
        logic [15:0]        id;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [1:0]         kind;
        logic [2:0]         place;
        logic [3:0]         len;
        logic [28:0]        can_id;
    } rule_t;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [RULE_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    cmd_t              evt_reg, evt_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [SLOT_W-1:0] rd_addr, free_idx;
    logic              free_found;
    logic              we;
    rule_t             wr_rule, rd_rule;

    logic              out_free, hit, emit, last_slot, rm_ok;
    logic [3:0]        len_sat;
    logic [7:0]        lo8, hi8;
    logic [15:0]       ser16;
    logic [63:0]       raw_data, can_data, keep_mask;
    logic              can_fits, can_wide;
    res_t              frame, reply;

    assign out_free  = !out_valid_reg || m_ready;
    assign last_slot = (idx_reg == SLOT_W'(RULE_SLOTS - 1));
    assign m_valid   = out_valid_reg;
    assign m_res     = out_reg;

    iermap_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (RULE_SLOTS),
        .AW    (SLOT_W)
    ) u_rule_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (free_idx),
        .wdata (wr_rule),
        .raddr (rd_addr),
        .rdata (rd_rule)
    );

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        wr_rule.dev    = cmd.device_index;
        wr_rule.etype  = cmd.event_type;
        wr_rule.id     = cmd.input_id;
        wr_rule.lo     = cmd.min_value;
        wr_rule.hi     = cmd.max_value;
        wr_rule.kind   = cmd.out_kind;
        wr_rule.place  = cmd.placement;
        wr_rule.len    = cmd.frame_length;
        wr_rule.can_id = cmd.can_id;
    end

    assign rm_ok = (32'(cmd.slot) < RULE_SLOTS) && valid_reg[cmd.slot[SLOT_W-1:0]];

    // frame for the slot under evaluation
    assign lo8     = evt_reg.value[7:0];
    assign hi8     = evt_reg.value[15:8];
    assign len_sat = (rd_rule.len > 4'd8) ? 4'd8 : rd_rule.len;

    assign hit = valid_reg[idx_reg]
              && (rd_rule.dev == evt_reg.device_index)
              && (rd_rule.etype == evt_reg.event_type)
              && (rd_rule.id == evt_reg.input_id)
              && (evt_reg.value >= rd_rule.lo)
              && (evt_reg.value <= rd_rule.hi);

    always_comb begin
        unique case (rd_rule.place)
            FMT_ASCII: ser16 = {8'd0, lo8 + ASCII_ZERO};
            FMT_LE16:  ser16 = {hi8, lo8};
            FMT_BE16:  ser16 = {lo8, hi8};
            default:   ser16 = {8'd0, lo8};
        endcase
    end

    assign can_fits = ({1'b0, rd_rule.place} < len_sat);
    assign can_wide = (({1'b0, rd_rule.place} + 4'd1) < len_sat);
    assign can_data = (can_wide ? {48'd0, hi8, lo8} : {56'd0, lo8})
                      << {rd_rule.place, 3'b000};
    assign raw_data = (rd_rule.kind == OUT_SERIAL) ? {48'd0, ser16} : can_data;
    assign keep_mask = len_sat[3] ? {64{1'b1}} : ~({64{1'b1}} << {len_sat[2:0], 3'b000});

    assign emit = hit && ((rd_rule.kind == OUT_SERIAL) || (rd_rule.kind == OUT_CAN && can_fits));

    always_comb begin
        frame              = '0;
        frame.result_kind  = (rd_rule.kind == OUT_SERIAL) ? RK_SERIAL : RK_CAN;
        frame.frame_id     = (rd_rule.kind == OUT_SERIAL) ? 29'd0 : rd_rule.can_id;
        frame.frame_bytes  = len_sat;
        frame.frame_data   = raw_data & keep_mask;
        frame.rules_in_use = 7'(cnt_reg);
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        evt_next        = evt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        cmd_pop         = 1'b0;
        we              = 1'b0;
        rd_addr         = idx_reg;
        reply           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.mode)
                        MODE_ADD: begin
                            if (out_free) begin
                                cmd_pop           = 1'b1;
                                reply.result_kind = RK_ADD;
                                reply.last        = 1'b1;
                                if (free_found) begin
                                    we                   = 1'b1;
                                    valid_next[free_idx] = 1'b1;
                                    cnt_next             = cnt_reg + 1'b1;
                                    reply.ok             = 1'b1;
                                    reply.reply_slot     = 6'(free_idx);
                                end
                                reply.rules_in_use = 7'(cnt_next);
                                out_valid_next     = 1'b1;
                                out_next           = reply;
                            end
                        end
                        MODE_REMOVE: begin
                            if (out_free) begin
                                cmd_pop           = 1'b1;
                                reply.result_kind = RK_REMOVE;
                                reply.last        = 1'b1;
                                if (rm_ok) begin
                                    valid_next[cmd.slot[SLOT_W-1:0]] = 1'b0;
                                    cnt_next = cnt_reg - 1'b1;
                                    reply.ok = 1'b1;
                                end
                                reply.rules_in_use = 7'(cnt_next);
                                out_valid_next     = 1'b1;
                                out_next           = reply;
                            end
                        end
                        MODE_EVENT: begin
                            cmd_pop         = 1'b1;
                            evt_next        = cmd;
                            idx_next        = '0;
                            rd_addr         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // a new frame must wait while the held one cannot leave
                if (!(emit && pend_valid_reg && !out_free)) begin
                    if (emit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = frame;
                    end
                    if (last_slot) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        evt_reg  <= evt_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> rtl/input_event_rule_mapper_unit.sv
// ----------------------------------------------------------------------------
// input_event_rule_mapper_unit
// Rule table that maps input events to serial or CAN frames.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                               | tuser       | tlast
//  ---------+-----+-------------------------------------+-------------+------
//  s_ req   | in  | event / rule fields, 128 bits       | mode        | -
//  m_ res   | out | frame or reply fields, 112 bits     | result kind | last
//
//  Add and remove: handled in the back part once the output register is free.
//  Event: dispatch, one rule RAM read per slot, then flush; the scan is paced
//  by the single read port of the rule RAM and can stall while m_tready is low.
//  Reset (aresetn low, synchronous) empties the table, queue and output.
//  The front keeps taking requests into a two-entry queue while the back
//  works or waits on m_tready; s_tready drops only when that queue is full.
//
`default_nettype none

module input_event_rule_mapper_unit #(
    parameter int RULE_SLOTS = iermap_pkg::RULE_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // device_index[7:0], event_type[11:8], input_id[27:12], value[43:28],
    // min_value[59:44], max_value[75:60], out_kind[77:76], placement[80:78],
    // frame_length[84:81], can_id[113:85], slot[121:114], zero pad above
    input  logic [iermap_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [iermap_pkg::S_TUSER_W-1:0] s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_id[28:0], frame_bytes[32:29], frame_data[96:33],
    // reply_slot[102:97], ok[103], rules_in_use[110:104], zero pad above
    output logic [iermap_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind[1:0]
    output logic [iermap_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast
);

    import iermap_pkg::*;

    // front -> queue
    logic         fq_valid, fq_ready;
    cmd_t         fq_cmd;

    // queue -> back
    logic         qb_valid, qb_pop;
    cmd_t         qb_cmd;

    res_t         res;
    out_payload_t op;

    // request unpack and mode filter
    iermap_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    // decouples request intake from the table scan
    iermap_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_pop),
        .pop_cmd    (qb_cmd)
    );

    // table, scan and output register
    iermap_back #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_pop   (qb_pop),
        .cmd       (qb_cmd),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    // result packing
    always_comb begin
        op.pad          = 1'b0;
        op.rules_in_use = res.rules_in_use;
        op.ok           = res.ok;
        op.reply_slot   = res.reply_slot;
        op.frame_data   = res.frame_data;
        op.frame_bytes  = res.frame_bytes;
        op.frame_id     = res.frame_id;
    end

    assign m_tdata = op;
    assign m_tuser = res.result_kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

>>> rtl/iermap_checker.sv
// ----------------------------------------------------------------------------
// iermap_checker
// Port-level checks of the input event rule mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "input_event_rule_mapper_unit_assert.svh"

module iermap_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [iermap_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [iermap_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                             m_tlast
);

    import iermap_pkg::*;

    out_payload_t                   op;
    logic                           is_reply;
    logic                           is_frame;
    logic [M_TDATA_W+M_TUSER_W:0]   m_bus;
    logic                           reply_shape;
    logic                           frame_shape;
    logic                           add_ok;

    assign op       = m_tdata;
    assign is_reply = (m_tuser == RK_ADD) || (m_tuser == RK_REMOVE);
    assign is_frame = (m_tuser == RK_SERIAL) || (m_tuser == RK_CAN);
    assign m_bus    = {m_tlast, m_tuser, m_tdata};

    assign reply_shape = m_tlast && (op.frame_data == 64'd0) && (op.frame_bytes == 4'd0);
    assign frame_shape = (op.frame_bytes <= 4'd8) && !op.ok && (op.reply_slot == 6'd0);
    assign add_ok      = m_tvalid && (m_tuser == RK_ADD) && op.ok;

    // stalled result holds
    `IERM_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_bus), "result changed while stalled")

    // an add or remove answers with exactly one result
    `IERM_ASSERT_HOLDS(a_reply_last, m_tvalid && is_reply, reply_shape, "reply not single or carries frame data")

    // frames never exceed eight bytes and carry no ok flag or reply slot
    `IERM_ASSERT_HOLDS(a_frame_shape, m_tvalid && is_frame, frame_shape, "malformed frame")

    // a successful add leaves at least one rule in use
    `IERM_ASSERT_HOLDS(a_add_count, add_ok, op.rules_in_use != 7'd0, "add ok with empty table")

endmodule

bind input_event_rule_mapper_unit iermap_checker u_iermap_checker (.*);

`default_nettype wire

>>> test/tb_input_event_rule_mapper_unit.sv
// ----------------------------------------------------------------------------
// Input event rule mapper testbench
// Drives add, remove and event requests through the slave stream, predicts
// every reply and frame from a behavioral copy of the rule table, and checks
// each result on the master stream in order.
// ----------------------------------------------------------------------------
module tb_input_event_rule_mapper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import iermap_pkg::*;

    localparam int SLOTS        = RULE_SLOTS_DEF;
    localparam int RANDOM_REQS  = 480;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 60;       // accepted requests before the long stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = SLOTS + 20;
    localparam int PRINT_MAX    = 100;

    // request mode the block drops without a result
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // rule output kinds
    localparam logic [1:0] OUT_SERIAL = 2'd0;
    localparam logic [1:0] OUT_CAN    = 2'd1;
    localparam logic [1:0] OUT_NONE   = 2'd2;
    localparam logic [1:0] OUT_UNUSED = 2'd3;

    // serial format codes; anything above BE16 falls back to raw
    localparam logic [2:0] FMT_RAW   = 3'd0;
    localparam logic [2:0] FMT_ASCII = 3'd1;
    localparam logic [2:0] FMT_LE16  = 3'd2;
    localparam logic [2:0] FMT_BE16  = 3'd3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct {
        logic [7:0]         dev;
        logic [3:0]         typ;
        logic [15:0]        id;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [1:0]         kind;
        logic [2:0]         place;
        logic [3:0]         len;
        logic [28:0]        cid;
    } rule_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [1:0]  mode;
        in_payload_t pay;
        bit          typed;
        res_t        want;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // behavioral copy of the rule table
    rule_t rule_tbl [SLOTS];
    bit    rule_live [SLOTS];
    int    live_rules = 0;

    res_t      results_due [$];     // replies and frames still to come, oldest first
    stim_row_t dir_rows [$];

    int   src_idle_pct = 21;
    int   dst_idle_pct = 67;
    logic hold_rx      = 1'b0;
    int   accepted     = 0;
    int   mismatches   = 0;
    int   cycle_count  = 0;

    input_event_rule_mapper_unit #(
        .RULE_SLOTS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Payload and reply builders
    // ------------------------------------------------------------------------
    function automatic in_payload_t rule_pay(logic [7:0] dev, logic [3:0] typ,
                                             logic [15:0] id, logic [15:0] lo,
                                             logic [15:0] hi, logic [1:0] kind,
                                             logic [2:0] place, logic [3:0] len,
                                             logic [28:0] cid);
        in_payload_t p;
        p = '0;
        p.device_index = dev;
        p.event_type   = typ;
        p.input_id     = id;
        p.min_value    = lo;
        p.max_value    = hi;
        p.out_kind     = kind;
        p.placement    = place;
        p.frame_length = len;
        p.can_id       = cid;
        return p;
    endfunction

    function automatic in_payload_t event_pay(logic [7:0] dev, logic [3:0] typ,
                                              logic [15:0] id, logic [15:0] val);
        in_payload_t p;
        p = '0;
        p.device_index = dev;
        p.event_type   = typ;
        p.input_id     = id;
        p.value        = val;
        return p;
    endfunction

    function automatic in_payload_t slot_pay(logic [7:0] s);
        in_payload_t p;
        p = '0;
        p.slot = s;
        return p;
    endfunction

    // add and remove replies are always the single, last result of a request
    function automatic res_t reply(logic [1:0] kind, logic [5:0] rslot, logic ok, int cnt);
        res_t r;
        r = '0;
        r.result_kind  = kind;
        r.reply_slot   = rslot;
        r.ok           = ok;
        r.rules_in_use = 7'(cnt);
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic void put_row(logic [1:0] mode, in_payload_t pay, bit typed, res_t want);
        stim_row_t row;
        row.mode  = mode;
        row.pay   = pay;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: updates the table copy and queues what the request causes
    // ------------------------------------------------------------------------
    function automatic void map_request(logic [1:0] mode, in_payload_t pay);
        int                 i;
        int                 free_slot;
        int                 n_before;
        logic [3:0]         len;
        logic [63:0]        data;
        logic [63:0]        mask;
        logic signed [15:0] ev_val;
        logic [7:0]         lo8;
        logic [7:0]         hi8;
        res_t               r;
        case (mode)
            MODE_ADD: begin
                // lowest free slot wins
                free_slot = -1;
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!rule_live[i]) free_slot = i;
                if (free_slot < 0) begin
                    results_due.push_back(reply(RK_ADD, 6'd0, 1'b0, live_rules));
                end else begin
                    rule_tbl[free_slot].dev   = pay.device_index;
                    rule_tbl[free_slot].typ   = pay.event_type;
                    rule_tbl[free_slot].id    = pay.input_id;
                    rule_tbl[free_slot].lo    = pay.min_value;
                    rule_tbl[free_slot].hi    = pay.max_value;
                    rule_tbl[free_slot].kind  = pay.out_kind;
                    rule_tbl[free_slot].place = pay.placement;
                    rule_tbl[free_slot].len   = pay.frame_length;
                    rule_tbl[free_slot].cid   = pay.can_id;
                    rule_live[free_slot] = 1'b1;
                    live_rules++;
                    results_due.push_back(reply(RK_ADD, 6'(free_slot), 1'b1, live_rules));
                end
            end
            MODE_REMOVE: begin
                if (pay.slot < SLOTS && rule_live[pay.slot]) begin
                    rule_live[pay.slot] = 1'b0;
                    live_rules--;
                    results_due.push_back(reply(RK_REMOVE, 6'd0, 1'b1, live_rules));
                end else begin
                    results_due.push_back(reply(RK_REMOVE, 6'd0, 1'b0, live_rules));
                end
            end
            MODE_EVENT: begin
                n_before = results_due.size();
                ev_val   = pay.value;
                lo8      = pay.value[7:0];
                hi8      = pay.value[15:8];
                for (i = 0; i < SLOTS; i++) begin
                    if (!rule_live[i] || rule_tbl[i].dev != pay.device_index ||
                        rule_tbl[i].typ != pay.event_type || rule_tbl[i].id != pay.input_id ||
                        ev_val < rule_tbl[i].lo || ev_val > rule_tbl[i].hi)
                        continue;
                    len  = (rule_tbl[i].len > 4'd8) ? 4'd8 : rule_tbl[i].len;
                    mask = (len == 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
                    r = '0;
                    r.rules_in_use = 7'(live_rules);
                    r.frame_bytes  = len;
                    if (rule_tbl[i].kind == OUT_SERIAL) begin
                        case (rule_tbl[i].place)
                            FMT_ASCII: data = {56'd0, 8'(lo8 + ASCII_ZERO)};
                            FMT_LE16:  data = {48'd0, hi8, lo8};
                            FMT_BE16:  data = {48'd0, lo8, hi8};
                            default:   data = {56'd0, lo8};
                        endcase
                        r.result_kind = RK_SERIAL;
                        r.frame_data  = data & mask;
                        results_due.push_back(r);
                    end else if (rule_tbl[i].kind == OUT_CAN) begin
                        // byte index past the frame: silent match
                        if (rule_tbl[i].place >= len) continue;
                        if (rule_tbl[i].place + 1 < len)
                            data = {48'd0, hi8, lo8} << (8 * rule_tbl[i].place);
                        else
                            data = {56'd0, lo8} << (8 * rule_tbl[i].place);
                        r.result_kind = RK_CAN;
                        r.frame_id    = rule_tbl[i].cid;
                        r.frame_data  = data & mask;
                        results_due.push_back(r);
                    end
                end
                if (results_due.size() > n_before)
                    results_due[results_due.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random request generator; leans on live rules so events really match
    // ------------------------------------------------------------------------
    task automatic draw_request(output logic [1:0] mode, output in_payload_t pay);
        int                 pick;
        int                 s;
        int                 lo_i;
        int                 hi_i;
        int                 live_q [$];
        logic signed [15:0] a;
        logic signed [15:0] b;
        // unused fields stay random so the block has to ignore them
        pay = {$urandom, $urandom, $urandom, $urandom};
        pay.pad = '0;
        for (s = 0; s < SLOTS; s++)
            if (rule_live[s]) live_q.push_back(s);
        pick = $urandom_range(99);
        if (pick < 2) begin
            mode = MODE_UNUSED;
        end else if (pick < 27) begin
            mode = MODE_ADD;
            // small key pool so several rules share a key
            if ($urandom_range(4) != 0) begin
                pay.device_index = 8'($urandom_range(2));
                pay.event_type   = 4'($urandom_range(1));
                pay.input_id     = $urandom_range(1) ? 16'hFFFF : 16'h0001;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    pay.min_value = 16'h8000;
                    pay.max_value = 16'h7FFF;
                end
                5: begin    // empty window
                    pay.min_value = 16'($urandom_range(32767, 1));
                    pay.max_value = pay.min_value - 16'd1;
                end
                6: begin    // single point
                    pay.max_value = pay.min_value;
                end
                default: begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                    pay.min_value = (a > b) ? b : a;
                    pay.max_value = (a > b) ? a : b;
                end
            endcase
            if ($urandom_range(9) == 0)
                pay.out_kind = $urandom_range(1) ? OUT_NONE : OUT_UNUSED;
            else
                pay.out_kind = $urandom_range(1) ? OUT_CAN : OUT_SERIAL;
        end else if (pick < 52) begin
            mode = MODE_REMOVE;
            if ($urandom_range(4) != 0) begin
                if (live_q.size() != 0 && $urandom_range(9) < 7)
                    pay.slot = 8'(live_q[$urandom_range(live_q.size() - 1)]);
                else
                    pay.slot = 8'($urandom_range(SLOTS - 1));
            end
        end else begin
            mode = MODE_EVENT;
            if (live_q.size() != 0 && $urandom_range(4) != 0) begin
                s = live_q[$urandom_range(live_q.size() - 1)];
                pay.device_index = rule_tbl[s].dev;
                pay.event_type   = rule_tbl[s].typ;
                pay.input_id     = rule_tbl[s].id;
                lo_i = rule_tbl[s].lo;
                hi_i = rule_tbl[s].hi;
                if (lo_i <= hi_i && $urandom_range(3) != 0)
                    pay.value = 16'(lo_i + $urandom_range(hi_i - lo_i));
                else if ($urandom_range(1))
                    pay.value = 16'($urandom_range(1) ? lo_i - 1 : hi_i + 1);
            end else if ($urandom_range(1)) begin
                pay.device_index = 8'($urandom_range(2));
                pay.event_type   = 4'($urandom_range(1));
                pay.input_id     = $urandom_range(1) ? 16'hFFFF : 16'h0001;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: optional gap, then hold the request until it is taken.
    // Called and returns at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] mode, input in_payload_t pay,
                                input bit typed, input res_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pay;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        map_request(mode, pay);
        // directed rows with a hand-written reply override the prediction
        if (typed) begin
            void'(results_due.pop_back());
            results_due.push_back(want);
        end
        accepted++;
        @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("MISMATCH cycle %0d %s: got 0x%0h, want 0x%0h",
                     cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed table, then three random phases of idling
    // ------------------------------------------------------------------------
    initial begin : stimulus
        in_payload_t all_ones;
        in_payload_t pay;
        logic [1:0]  mode;
        int          sent;
        int          ph;
        int          k;

        all_ones = '1;
        all_ones.pad = '0;

        // remove on an empty table fails
        put_row(MODE_REMOVE, slot_pay(8'd0), 1'b1, reply(RK_REMOVE, 6'd0, 1'b0, 0));
        // key 0/0/0, full window: each serial format, each CAN placement case
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, FMT_RAW, 4'd1, 0),
                1'b1, reply(RK_ADD, 6'd0, 1'b1, 1));
        // length above 8 saturates
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, FMT_ASCII, 4'd15, 0),
                1'b1, reply(RK_ADD, 6'd1, 1'b1, 2));
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, FMT_LE16, 4'd8, 0),
                1'b1, reply(RK_ADD, 6'd2, 1'b1, 3));
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, FMT_BE16, 4'd2, 0),
                1'b1, reply(RK_ADD, 6'd3, 1'b1, 4));
        // unknown format falls back to raw; zero length
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, 3'd7, 4'd0, 0),
                1'b1, reply(RK_ADD, 6'd4, 1'b1, 5));
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_CAN, 3'd0, 4'd8, 29'h1FFFFFFF),
                1'b1, reply(RK_ADD, 6'd5, 1'b1, 6));
        // last byte of the frame: only the low byte fits
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_CAN, 3'd7, 4'd8, 29'h0ABCDEF),
                1'b1, reply(RK_ADD, 6'd6, 1'b1, 7));
        // index equal to length: matches but emits nothing
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_CAN, 3'd3, 4'd3, 29'h123),
                1'b1, reply(RK_ADD, 6'd7, 1'b1, 8));
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_NONE, 3'd0, 4'd8, 0),
                1'b1, reply(RK_ADD, 6'd8, 1'b1, 9));
        // min above max: never matches
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h0001, 16'h0000, OUT_SERIAL, FMT_RAW, 4'd8, 0),
                1'b1, reply(RK_ADD, 6'd9, 1'b1, 10));
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_UNUSED, 3'd0, 4'd8, 0),
                1'b1, reply(RK_ADD, 6'd10, 1'b1, 11));
        // value extremes and an ASCII wrap through the whole rule set
        put_row(MODE_EVENT, event_pay(0, 0, 0, 16'h8000), 1'b0, '0);
        put_row(MODE_EVENT, event_pay(0, 0, 0, 16'h7FFF), 1'b0, '0);
        put_row(MODE_EVENT, event_pay(0, 0, 0, 16'h12F0), 1'b0, '0);
        // unused mode code is dropped
        put_row(MODE_UNUSED, all_ones, 1'b0, '0);
        put_row(MODE_REMOVE, slot_pay(8'hFF), 1'b1, reply(RK_REMOVE, 6'd0, 1'b0, 11));
        put_row(MODE_REMOVE, slot_pay(8'd3), 1'b1, reply(RK_REMOVE, 6'd0, 1'b1, 10));
        // key at field maxima; the freed slot 3 is taken first
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'h7FFF, 16'h7FFF, OUT_CAN, 3'd6,
                4'd7, 29'd0), 1'b1, reply(RK_ADD, 6'd3, 1'b1, 11));
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'h0001, OUT_SERIAL, 3'd4,
                4'd8, 0), 1'b1, reply(RK_ADD, 6'd11, 1'b1, 12));
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'h8000, 16'h7FFF, OUT_CAN, 3'd6,
                4'd15, 29'h15555555), 1'b1, reply(RK_ADD, 6'd12, 1'b1, 13));
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'h8000, 16'h7FFF, OUT_CAN, 3'd0,
                4'd1, 29'h0AAAAAAA), 1'b1, reply(RK_ADD, 6'd13, 1'b1, 14));
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'h8000, 16'h7FFF, OUT_SERIAL,
                FMT_LE16, 4'd1, 0), 1'b1, reply(RK_ADD, 6'd14, 1'b1, 15));
        put_row(MODE_ADD, rule_pay(8'hFF, 4'hF, 16'hFFFF, 16'h7FFF, 16'h7FFF, OUT_SERIAL,
                FMT_ASCII, 4'd1, 0), 1'b1, reply(RK_ADD, 6'd15, 1'b1, 16));
        // table full
        put_row(MODE_ADD, rule_pay(0, 0, 0, 16'h8000, 16'h7FFF, OUT_SERIAL, FMT_RAW, 4'd1, 0),
                1'b1, reply(RK_ADD, 6'd0, 1'b0, 16));
        put_row(MODE_EVENT, event_pay(8'hFF, 4'hF, 16'hFFFF, 16'h7FFF), 1'b0, '0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++)
            send_request(dir_rows[k].mode, dir_rows[k].pay, dir_rows[k].typed, dir_rows[k].want);

        for (ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                src_idle_pct = 67;
                dst_idle_pct = 21;
            end else if (ph == 2) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            sent = 0;
            while (sent < RANDOM_REQS / 3) begin
                draw_request(mode, pay);
                send_request(mode, pay, 1'b0, '0);
                if (mode != MODE_UNUSED) sent++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give the block time to show anything extra
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (results_due.size() != 0)
            note_mismatch("results never delivered", results_due.size(), 0);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver pacing; hold_rx forces one long stall to back up the input
    // ------------------------------------------------------------------------
    initial begin : rx_pacing
        forever begin
            @(negedge aclk);
            m_tready <= !hold_rx && ($urandom_range(99) >= dst_idle_pct);
        end
    end

    initial begin : rx_holdoff
        wait (accepted >= HOLD_AT);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_payload_t got;
        res_t         want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (results_due.size() == 0) begin
                note_mismatch("result with nothing pending", m_tuser, 0);
            end else begin
                want = results_due.pop_front();
                if (m_tuser != want.result_kind)
                    note_mismatch("result_kind", m_tuser, want.result_kind);
                if (got.frame_id != want.frame_id)
                    note_mismatch("frame_id", got.frame_id, want.frame_id);
                if (got.frame_bytes != want.frame_bytes)
                    note_mismatch("frame_bytes", got.frame_bytes, want.frame_bytes);
                if (got.frame_data != want.frame_data)
                    note_mismatch("frame_data", got.frame_data, want.frame_data);
                if (got.reply_slot != want.reply_slot)
                    note_mismatch("reply_slot", got.reply_slot, want.reply_slot);
                if (got.ok != want.ok)
                    note_mismatch("ok", got.ok, want.ok);
                if (got.rules_in_use != want.rules_in_use)
                    note_mismatch("rules_in_use", got.rules_in_use, want.rules_in_use);
                if (m_tlast != want.last)
                    note_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
